// File: hdl/ptq_pkg.sv
// shared types and constants for the parent array tree query block
package ptq_pkg;

    localparam int MAX_NODES_DEF = 64;
    localparam int INDEX_CAP     = 64;
    localparam int VAL_W         = 7;
    localparam int IDX_W         = 6;
    localparam int CMD_W         = 3;

    // parent value that marks a root
    localparam logic [VAL_W-1:0] ROOT_MARK = 7'h7F;
    localparam logic [VAL_W-1:0] COUNT_RESET = 7'd64;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE    = 3'd0,
        CMD_LEVEL    = 3'd1,
        CMD_LCA      = 3'd2,
        CMD_CHILDREN = 3'd3,
        CMD_SIBLINGS = 3'd4,
        CMD_AT_LEVEL = 3'd5,
        CMD_HEIGHT   = 3'd6,
        CMD_ROOT     = 3'd7
    } cmd_t;

    typedef struct packed {
        logic [VAL_W-1:0] answer;
        logic             last;
        logic             empty_res;
        logic             fault;
    } result_t;

endpackage

// File: hdl/ptq_if.sv
// request and result channel interfaces
interface ptq_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         cmd;
    logic [5:0]         node;
    logic [5:0]         other_node;
    logic signed [6:0]  parent_node;
    logic [6:0]         wanted_level;

    modport source (output valid, cmd, node, other_node, parent_node, wanted_level,
                    input ready);
    modport sink   (input valid, cmd, node, other_node, parent_node, wanted_level,
                    output ready);
endinterface

interface ptq_rsp_if;
    logic       valid;
    logic       ready;
    logic [6:0] answer;
    logic       last;
    logic       empty_res;
    logic       fault;

    modport source (output valid, answer, last, empty_res, fault, input ready);
    modport sink   (input valid, answer, last, empty_res, fault, output ready);
endinterface

// File: hdl/ptq_mem.sv
// parent table memory, one write and one read port, registered read
module ptq_mem #(
    parameter int DEPTH = ptq_pkg::MAX_NODES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                    clk,
    input  logic                    we,
    input  logic [AW-1:0]           waddr,
    input  logic [ptq_pkg::VAL_W-1:0] wdata,
    input  logic                    re,
    input  logic [AW-1:0]           raddr,
    output logic [ptq_pkg::VAL_W-1:0] rdata
);
    import ptq_pkg::*;

    logic [VAL_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hdl/ptq_seq.sv
// command sequencer: chain walks, table scans and result emission
module ptq_seq #(
    parameter int DEPTH = ptq_pkg::MAX_NODES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    ptq_req_if.sink                   req,
    input  logic [ptq_pkg::VAL_W-1:0] n_eff,
    output logic                      mem_we,
    output logic [AW-1:0]             mem_waddr,
    output logic [ptq_pkg::VAL_W-1:0] mem_wdata,
    output logic                      mem_re,
    output logic [AW-1:0]             mem_raddr,
    input  logic [ptq_pkg::VAL_W-1:0] mem_rdata,
    output logic                      emit_valid,
    output ptq_pkg::result_t          emit_data,
    input  logic                      emit_ok
);
    import ptq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_WRD, S_WCHK, S_SCRD, S_SCCHK, S_SIBRD, S_SIBGET,
        S_CTOP, S_CA, S_CB, S_CAB1, S_CAB2, S_ADV, S_EMIT
    } state_t;

    state_t           state_reg, ret_reg;
    cmd_t             cmd_reg;
    logic [IDX_W-1:0] node_reg, other_reg;
    logic [VAL_W-1:0] want_reg, n_reg;
    logic [AW-1:0]    cur_reg, a_reg, b_reg;
    logic [VAL_W-1:0] d_reg, steps_reg, i_reg, da_reg, db_reg, best_reg, pn_reg;
    logic [VAL_W-1:0] hit_idx_reg;
    logic             found_reg, hit_v_reg, pass2_reg, lcab_reg;
    result_t          em_reg;

    logic             accept;
    logic             bad_a, bad_b;
    logic [VAL_W-1:0] i_inc;
    logic             scan_hit;

    assign req.ready  = (state_reg == S_IDLE);
    assign accept     = req.valid && req.ready;
    assign bad_a      = {1'b0, req.node} >= n_eff;
    assign bad_b      = {1'b0, req.other_node} >= n_eff;
    assign i_inc      = i_reg + 7'd1;
    assign emit_valid = (state_reg == S_EMIT);
    assign emit_data  = em_reg;

    assign mem_we    = accept && (cmd_t'(req.cmd) == CMD_WRITE) && !bad_a;
    assign mem_waddr = AW'(req.node);
    assign mem_wdata = req.parent_node;

    always_comb
    begin
        if (cmd_reg == CMD_CHILDREN)
        begin
            scan_hit = (mem_rdata == {1'b0, node_reg});
        end
        else
        begin
            scan_hit = (i_reg != {1'b0, node_reg}) && (mem_rdata == pn_reg);
        end
    end

    // read port steering
    always_comb
    begin
        mem_re    = 1'b0;
        mem_raddr = cur_reg;
        unique case (state_reg)
            S_WRD:
            begin
                mem_re = 1'b1;
            end
            S_SCRD:
            begin
                mem_re    = 1'b1;
                mem_raddr = i_reg[AW-1:0];
            end
            S_SIBRD:
            begin
                mem_re    = 1'b1;
                mem_raddr = AW'(node_reg);
            end
            S_CTOP:
            begin
                mem_re    = 1'b1;
                mem_raddr = (db_reg > da_reg) ? b_reg : a_reg;
            end
            S_CAB1:
            begin
                mem_re    = 1'b1;
                mem_raddr = b_reg;
            end
            default:
            begin
                mem_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ret_reg     <= S_IDLE;
            cmd_reg     <= CMD_WRITE;
            node_reg    <= '0;
            other_reg   <= '0;
            want_reg    <= '0;
            n_reg       <= '0;
            cur_reg     <= '0;
            a_reg       <= '0;
            b_reg       <= '0;
            d_reg       <= '0;
            steps_reg   <= '0;
            i_reg       <= '0;
            da_reg      <= '0;
            db_reg      <= '0;
            best_reg    <= '0;
            pn_reg      <= '0;
            hit_idx_reg <= '0;
            found_reg   <= 1'b0;
            hit_v_reg   <= 1'b0;
            pass2_reg   <= 1'b0;
            lcab_reg    <= 1'b0;
            em_reg      <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg   <= cmd_t'(req.cmd);
                        node_reg  <= req.node;
                        other_reg <= req.other_node;
                        want_reg  <= req.wanted_level;
                        n_reg     <= n_eff;
                        hit_v_reg <= 1'b0;
                        pass2_reg <= 1'b0;
                        lcab_reg  <= 1'b0;
                        found_reg <= 1'b0;
                        i_reg     <= '0;
                        d_reg     <= 7'd1;
                        steps_reg <= '0;
                        ret_reg   <= S_IDLE;
                        em_reg    <= '{answer: '0, last: 1'b1, empty_res: 1'b0, fault: 1'b1};
                        unique case (cmd_t'(req.cmd))
                            CMD_WRITE:
                            begin
                                em_reg.fault <= bad_a;
                                state_reg    <= S_EMIT;
                            end
                            CMD_LEVEL:
                            begin
                                cur_reg   <= AW'(req.node);
                                state_reg <= bad_a ? S_EMIT : S_WRD;
                            end
                            CMD_LCA:
                            begin
                                cur_reg   <= AW'(req.node);
                                state_reg <= (bad_a || bad_b) ? S_EMIT : S_WRD;
                            end
                            CMD_CHILDREN:
                            begin
                                state_reg <= bad_a ? S_EMIT : S_SCRD;
                            end
                            CMD_SIBLINGS:
                            begin
                                state_reg <= bad_a ? S_EMIT : S_SIBRD;
                            end
                            CMD_AT_LEVEL:
                            begin
                                cur_reg   <= '0;
                                state_reg <= S_WRD;
                            end
                            CMD_HEIGHT:
                            begin
                                cur_reg   <= '0;
                                best_reg  <= 7'd1;
                                state_reg <= S_WRD;
                            end
                            CMD_ROOT:
                            begin
                                best_reg  <= '0;
                                state_reg <= S_SCRD;
                            end
                        endcase
                    end
                end
                S_WRD:
                begin
                    if (steps_reg == n_reg)
                    begin
                        em_reg    <= '{answer: '0, last: 1'b1, empty_res: 1'b0, fault: 1'b1};
                        ret_reg   <= S_IDLE;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_WCHK;
                    end
                end
                S_WCHK:
                begin
                    if (mem_rdata == ROOT_MARK)
                    begin
                        // walk done, level in d_reg
                        unique case (cmd_reg)
                            CMD_LEVEL:
                            begin
                                em_reg    <= '{answer: d_reg, last: 1'b1, empty_res: 1'b0,
                                               fault: 1'b0};
                                ret_reg   <= S_IDLE;
                                state_reg <= S_EMIT;
                            end
                            CMD_LCA:
                            begin
                                if (!lcab_reg)
                                begin
                                    da_reg    <= d_reg;
                                    lcab_reg  <= 1'b1;
                                    cur_reg   <= AW'(other_reg);
                                    d_reg     <= 7'd1;
                                    steps_reg <= '0;
                                    state_reg <= S_WRD;
                                end
                                else
                                begin
                                    db_reg    <= d_reg;
                                    a_reg     <= AW'(node_reg);
                                    b_reg     <= AW'(other_reg);
                                    state_reg <= S_CTOP;
                                end
                            end
                            CMD_HEIGHT:
                            begin
                                if (d_reg > best_reg)
                                begin
                                    best_reg <= d_reg;
                                end
                                state_reg <= S_ADV;
                            end
                            default:
                            begin
                                // nodes at level: first pass only checks chains
                                if (pass2_reg && (d_reg == want_reg))
                                begin
                                    hit_v_reg   <= 1'b1;
                                    hit_idx_reg <= i_reg;
                                    if (hit_v_reg)
                                    begin
                                        em_reg    <= '{answer: hit_idx_reg, last: 1'b0,
                                                       empty_res: 1'b0, fault: 1'b0};
                                        ret_reg   <= S_ADV;
                                        state_reg <= S_EMIT;
                                    end
                                    else
                                    begin
                                        state_reg <= S_ADV;
                                    end
                                end
                                else
                                begin
                                    state_reg <= S_ADV;
                                end
                            end
                        endcase
                    end
                    else if (mem_rdata[VAL_W-1] || (mem_rdata >= n_reg))
                    begin
                        em_reg    <= '{answer: '0, last: 1'b1, empty_res: 1'b0, fault: 1'b1};
                        ret_reg   <= S_IDLE;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        cur_reg   <= mem_rdata[AW-1:0];
                        d_reg     <= d_reg + 7'd1;
                        steps_reg <= steps_reg + 7'd1;
                        state_reg <= S_WRD;
                    end
                end
                S_SIBRD:
                begin
                    state_reg <= S_SIBGET;
                end
                S_SIBGET:
                begin
                    pn_reg    <= mem_rdata;
                    state_reg <= S_SCRD;
                end
                S_SCRD:
                begin
                    state_reg <= S_SCCHK;
                end
                S_SCCHK:
                begin
                    if (cmd_reg == CMD_ROOT)
                    begin
                        if (mem_rdata == ROOT_MARK)
                        begin
                            best_reg  <= i_reg;
                            found_reg <= 1'b1;
                        end
                        state_reg <= S_ADV;
                    end
                    else if (scan_hit)
                    begin
                        hit_v_reg   <= 1'b1;
                        hit_idx_reg <= i_reg;
                        if (hit_v_reg)
                        begin
                            em_reg    <= '{answer: hit_idx_reg, last: 1'b0, empty_res: 1'b0,
                                           fault: 1'b0};
                            ret_reg   <= S_ADV;
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_ADV;
                        end
                    end
                    else
                    begin
                        state_reg <= S_ADV;
                    end
                end
                S_ADV:
                begin
                    ret_reg <= S_IDLE;
                    if (i_inc == n_reg)
                    begin
                        if (cmd_reg == CMD_HEIGHT)
                        begin
                            em_reg    <= '{answer: best_reg, last: 1'b1, empty_res: 1'b0,
                                           fault: 1'b0};
                            state_reg <= S_EMIT;
                        end
                        else if (cmd_reg == CMD_ROOT)
                        begin
                            em_reg    <= '{answer: found_reg ? best_reg : '0, last: 1'b1,
                                           empty_res: 1'b0, fault: !found_reg};
                            state_reg <= S_EMIT;
                        end
                        else if ((cmd_reg == CMD_AT_LEVEL) && !pass2_reg)
                        begin
                            pass2_reg <= 1'b1;
                            i_reg     <= '0;
                            cur_reg   <= '0;
                            d_reg     <= 7'd1;
                            steps_reg <= '0;
                            state_reg <= S_WRD;
                        end
                        else
                        begin
                            em_reg    <= '{answer: hit_v_reg ? hit_idx_reg : '0, last: 1'b1,
                                           empty_res: !hit_v_reg, fault: 1'b0};
                            state_reg <= S_EMIT;
                        end
                    end
                    else
                    begin
                        i_reg <= i_inc;
                        if ((cmd_reg == CMD_AT_LEVEL) || (cmd_reg == CMD_HEIGHT))
                        begin
                            cur_reg   <= i_inc[AW-1:0];
                            d_reg     <= 7'd1;
                            steps_reg <= '0;
                            state_reg <= S_WRD;
                        end
                        else
                        begin
                            state_reg <= S_SCRD;
                        end
                    end
                end
                S_CTOP:
                begin
                    ret_reg <= S_IDLE;
                    if (da_reg > db_reg)
                    begin
                        state_reg <= S_CA;
                    end
                    else if (db_reg > da_reg)
                    begin
                        state_reg <= S_CB;
                    end
                    else if (a_reg == b_reg)
                    begin
                        em_reg    <= '{answer: VAL_W'(a_reg), last: 1'b1, empty_res: 1'b0,
                                       fault: 1'b0};
                        state_reg <= S_EMIT;
                    end
                    else if (da_reg <= 7'd1)
                    begin
                        em_reg    <= '{answer: '0, last: 1'b1, empty_res: 1'b0, fault: 1'b1};
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_CAB1;
                    end
                end
                S_CA:
                begin
                    a_reg     <= mem_rdata[AW-1:0];
                    da_reg    <= da_reg - 7'd1;
                    state_reg <= S_CTOP;
                end
                S_CB:
                begin
                    b_reg     <= mem_rdata[AW-1:0];
                    db_reg    <= db_reg - 7'd1;
                    state_reg <= S_CTOP;
                end
                S_CAB1:
                begin
                    a_reg     <= mem_rdata[AW-1:0];
                    state_reg <= S_CAB2;
                end
                S_CAB2:
                begin
                    b_reg     <= mem_rdata[AW-1:0];
                    da_reg    <= da_reg - 7'd1;
                    db_reg    <= db_reg - 7'd1;
                    state_reg <= S_CTOP;
                end
                S_EMIT:
                begin
                    if (emit_ok)
                    begin
                        state_reg <= ret_reg;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: hdl/parent_array_tree_query.sv
// parent array tree query: one request at a time
// height and nodes at level walk the chain from every node
// the next request is taken once the last result of the current one sits in the output register
// reset: asynchronous, active low; node count returns to 64, the parent table is not cleared
module parent_array_tree_query #(
    parameter int MAX_NODES = ptq_pkg::MAX_NODES_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [ptq_pkg::VAL_W-1:0] cfg_wdata,
    ptq_req_if.sink                   req,
    ptq_rsp_if.source                 rsp
);
    import ptq_pkg::*;

    // indices are six bits wide, so the table never needs more than 64 entries
    localparam int DEPTH = (MAX_NODES < INDEX_CAP) ? MAX_NODES : INDEX_CAP;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [VAL_W-1:0] node_count_reg;
    logic [VAL_W-1:0] n_clip, n_eff;

    logic             mem_we, mem_re;
    logic [AW-1:0]    mem_waddr, mem_raddr;
    logic [VAL_W-1:0] mem_wdata, mem_rdata;

    logic             emit_valid, emit_ok;
    result_t          emit_data;

    logic             out_valid_reg;
    result_t          out_data_reg;

    // node count register, to be written only while the block is idle; the block itself does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= COUNT_RESET;
        end
        else if (cfg_we)
        begin
            node_count_reg <= cfg_wdata;
        end
    end

    // effective count limited to 1..DEPTH
    assign n_clip = (node_count_reg > VAL_W'(DEPTH)) ? VAL_W'(DEPTH) : node_count_reg;
    assign n_eff  = (n_clip == '0) ? 7'd1 : n_clip;

    ptq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // the sequencer never writes and reads in the same cycle, so no forwarding is needed
    ptq_seq #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .n_eff      (n_eff),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata),
        .emit_valid (emit_valid),
        .emit_data  (emit_data),
        .emit_ok    (emit_ok)
    );

    // output register: the sequencer moves on as soon as its result is loaded
    assign emit_ok = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else if (emit_valid && emit_ok)
        begin
            out_valid_reg <= 1'b1;
            out_data_reg  <= emit_data;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.answer    = out_data_reg.answer;
    assign rsp.last      = out_data_reg.last;
    assign rsp.empty_res = out_data_reg.empty_res;
    assign rsp.fault     = out_data_reg.fault;

endmodule

// File: hdl/ptq_checker.sv
// port level checks for the parent array tree query block
module ptq_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [6:0] rsp_answer,
    input logic       rsp_last,
    input logic       rsp_empty_res,
    input logic       rsp_fault
);

    // a stalled result stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    // one request at a time
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    // a fault result ends its request and carries no answer
    a_fault_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_fault |-> rsp_last && !rsp_empty_res && (rsp_answer == 7'd0))
        else $error("malformed fault result");

    // an empty list ends the request
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_empty_res |-> rsp_last && !rsp_fault && (rsp_answer == 7'd0))
        else $error("malformed empty result");

endmodule

bind parent_array_tree_query ptq_checker u_ptq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_answer    (rsp.answer),
    .rsp_last      (rsp.last),
    .rsp_empty_res (rsp.empty_res),
    .rsp_fault     (rsp.fault)
);

// File: sim/parent_array_tree_query_tb.sv
// testbench for the parent array tree query block: predicted results checked against the result channel
module parent_array_tree_query_tb;
    import ptq_pkg::*;

    // one request as held in the pending queue
    typedef struct {
        cmd_t             cmd;
        logic [5:0]       node;
        logic [5:0]       other_node;
        logic signed [6:0] parent_node;
        logic [6:0]       wanted_level;
        int               hold;   // 0: plain; 1: wait until drained before sending
    } request_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [VAL_W-1:0] cfg_wdata;

    ptq_req_if req_ch();
    ptq_rsp_if rsp_ch();

    parent_array_tree_query uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch.sink),
        .rsp       (rsp_ch.source)
    );

    // shadow of the block's state
    logic signed [6:0] shadow_parent [0:63];
    int                shadow_count;

    request_t pending_reqs[$];
    result_t  expected_results[$];
    int       error_count;
    int       sent_count;
    int       idle_cycles;
    bit       hold_off;        // long receiver stall requested
    int       hold_left;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    task automatic report(input string what);
    begin
        error_count++;
        $display("mismatch: %s", what);
    end
    endtask

    // level of a node, root is 1; returns 0 on a broken chain
    function automatic int tree_level(input int node, input int n);
        int cur;
        int d;
        int p;
    begin
        cur = node;
        d = 1;
        for (int s = 0; s < n; s++)
        begin
            p = shadow_parent[cur];
            if (p == -1)
                return d;
            if (p < 0 || p >= n)
                return 0;
            cur = p;
            d++;
        end
        return 0;
    end
    endfunction

    function automatic result_t mk(input int ans, input bit lst, input bit emp, input bit flt);
        result_t r;
    begin
        r.answer = ans[6:0];
        r.last = lst;
        r.empty_res = emp;
        r.fault = flt;
        return r;
    end
    endfunction

    // compute expected results of one accepted request and update the shadow table
    task automatic predict_tree_query(input request_t q);
        int n;
        int a;
        int b;
        int da;
        int db;
        int d;
        int best;
        int hits;
        bit bad;
        bit hit;
        result_t run[$];
    begin
        n = shadow_count;
        if (n > 64) n = 64;
        if (n < 1) n = 1;
        run = {};
        bad = 0;
        case (q.cmd)
            CMD_WRITE:
            begin
                if (q.node >= n)
                    bad = 1;
                else
                begin
                    shadow_parent[q.node] = q.parent_node;
                    run.push_back(mk(0, 1, 0, 0));
                end
            end
            CMD_LEVEL:
            begin
                d = (q.node < n) ? tree_level(q.node, n) : 0;
                if (d == 0)
                    bad = 1;
                else
                    run.push_back(mk(d, 1, 0, 0));
            end
            CMD_LCA:
            begin
                a = q.node;
                b = q.other_node;
                if (a >= n || b >= n)
                    bad = 1;
                else
                begin
                    da = tree_level(a, n);
                    db = tree_level(b, n);
                    if (da == 0 || db == 0)
                        bad = 1;
                    else
                    begin
                        while (da > db)
                        begin
                            a = shadow_parent[a];
                            da--;
                        end
                        while (db > da)
                        begin
                            b = shadow_parent[b];
                            db--;
                        end
                        while (a != b && !bad)
                        begin
                            if (da <= 1)
                                bad = 1;
                            else
                            begin
                                a = shadow_parent[a];
                                b = shadow_parent[b];
                                da--;
                            end
                        end
                        if (!bad)
                            run.push_back(mk(a, 1, 0, 0));
                    end
                end
            end
            CMD_CHILDREN, CMD_SIBLINGS, CMD_AT_LEVEL:
            begin
                if (q.cmd != CMD_AT_LEVEL && q.node >= n)
                    bad = 1;
                if (q.cmd == CMD_AT_LEVEL)
                    for (int i = 0; i < n; i++)
                        if (tree_level(i, n) == 0)
                            bad = 1;
                if (!bad)
                begin
                    hits = 0;
                    for (int i = 0; i < n; i++)
                    begin
                        if (q.cmd == CMD_CHILDREN)
                            hit = (shadow_parent[i] == $signed({1'b0, q.node}));
                        else if (q.cmd == CMD_SIBLINGS)
                            hit = (i != q.node) && (shadow_parent[i] == shadow_parent[q.node]);
                        else
                            hit = (tree_level(i, n) == q.wanted_level);
                        if (hit)
                        begin
                            run.push_back(mk(i, 0, 0, 0));
                            hits++;
                        end
                    end
                    if (hits == 0)
                        run.push_back(mk(0, 1, 1, 0));
                    else
                        run[hits-1].last = 1'b1;
                end
            end
            CMD_HEIGHT:
            begin
                best = 1;
                for (int i = 0; i < n; i++)
                begin
                    d = tree_level(i, n);
                    if (d == 0)
                        bad = 1;
                    else if (d > best)
                        best = d;
                end
                if (!bad)
                    run.push_back(mk(best, 1, 0, 0));
            end
            default:
            begin
                best = -1;
                for (int i = 0; i < n; i++)
                    if (shadow_parent[i] == -1)
                        best = i;
                if (best < 0)
                    bad = 1;
                else
                    run.push_back(mk(best, 1, 0, 0));
            end
        endcase
        if (bad)
            expected_results.push_back(mk(0, 1, 0, 1));
        else
            foreach (run[i])
                expected_results.push_back(run[i]);
    end
    endtask

    // -- driver: bursts of requests with random gaps --
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            // request taken at this edge
            if (req_ch.valid && req_ch.ready)
            begin
                predict_tree_query(pending_reqs.pop_front());
                sent_count++;
            end
            if (!(req_ch.valid && !req_ch.ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_reqs.size() == 0)
                    req_ch.valid <= 1'b0;
                else if (pending_reqs[0].hold && expected_results.size() != 0)
                    req_ch.valid <= 1'b0;   // pause until drained
                else
                begin
                    req_ch.valid        <= 1'b1;
                    req_ch.cmd          <= pending_reqs[0].cmd;
                    req_ch.node         <= pending_reqs[0].node;
                    req_ch.other_node   <= pending_reqs[0].other_node;
                    req_ch.parent_node  <= pending_reqs[0].parent_node;
                    req_ch.wanted_level <= pending_reqs[0].wanted_level;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // -- monitor and receiver stall pattern --
    int stall_phase;
    result_t got;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_phase = 0;
            hold_left = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got = mk(rsp_ch.answer, rsp_ch.last, rsp_ch.empty_res, rsp_ch.fault);
                if (expected_results.size() == 0)
                    report($sformatf("unexpected result answer=%0d", got.answer));
                else if (got !== expected_results[0])
                begin
                    report($sformatf("answer %0d/%0d last %0b/%0b empty %0b/%0b fault %0b/%0b",
                        got.answer, expected_results[0].answer,
                        got.last, expected_results[0].last,
                        got.empty_res, expected_results[0].empty_res,
                        got.fault, expected_results[0].fault));
                    void'(expected_results.pop_front());
                end
                else
                    void'(expected_results.pop_front());
            end
            // long hold-off counted here so the block backs up
            if (hold_off && hold_left == 0)
            begin
                hold_left = 400;
                hold_off = 0;
            end
            stall_phase = (stall_phase + 1) % 29;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (stall_phase < 10)
                rsp_ch.ready <= 1'b1;          // stretch with no stalls
            else
                rsp_ch.ready <= ($urandom_range(0, 2) != 0);
        end
    end

    // -- watchdog: cycles with no handshake on either side --
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 40000)
        begin
            $display("parent_array_tree_query_tb: done, errors");
            $finish;
        end
    end

    // queue helpers
    task automatic add_req(input cmd_t c, input int nd, input int ot, input int par,
                           input int lvl, input int hold);
        request_t q;
    begin
        q.cmd = c;
        q.node = nd[5:0];
        q.other_node = ot[5:0];
        q.parent_node = par[6:0];
        q.wanted_level = lvl[6:0];
        q.hold = hold;
        pending_reqs.push_back(q);
    end
    endtask

    // drain everything, then let the block settle before a register write
    task automatic wait_drained();
    begin
        while (pending_reqs.size() != 0 || req_ch.valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    end
    endtask

    task automatic write_count(input int cnt);
    begin
        cfg_we <= 1'b1;
        cfg_wdata <= cnt[6:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow_count = cnt & 8'h7F;
        @(posedge clk);
    end
    endtask

    // random tree over nodes 0..n-1, built as well-formed writes; a deep chain or extra roots at times
    task automatic build_tree(input int n, input int shape);
        int p;
    begin
        for (int i = 0; i < n; i++)
        begin
            if (i == 0)
                p = -1;
            else if (shape == 1)
                p = i - 1;                          // deep chain
            else
                p = $urandom_range(0, i - 1);
            if (shape == 2 && i == $urandom_range(0, n - 1))
                p = -1;                              // extra root
            add_req(CMD_WRITE, i, 0, p, 0, 0);
        end
    end
    endtask

    function automatic int rnd_query_node(input int n);
    begin
        return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1);
    end
    endfunction

    task automatic random_queries(input int n, input int cnt);
        int c;
        int tries;
    begin
        for (int k = 0; k < cnt; k++)
        begin
            c = $urandom_range(0, 7);
            if (c == CMD_WRITE)
            begin
                // write noise: may break the chain, bad index, out-of-range parent
                tries = $urandom_range(0, 9);
                add_req(CMD_WRITE, (tries == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1),
                        $urandom_range(0, 63),
                        (tries == 1) ? $urandom_range(0, 127) - 64 : $urandom_range(0, n) - 1,
                        $urandom_range(0, 127), 0);
            end
            else
                add_req(cmd_t'(c), rnd_query_node(n), rnd_query_node(n),
                        $urandom_range(0, 127) - 64,
                        ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 8),
                        0);
        end
    end
    endtask

    int phase_n;

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.cmd = CMD_WRITE;
        req_ch.node = '0;
        req_ch.other_node = '0;
        req_ch.parent_node = '0;
        req_ch.wanted_level = '0;
        rsp_ch.ready = 1'b0;
        error_count = 0;
        sent_count = 0;
        idle_cycles = 0;
        hold_off = 0;
        shadow_count = 64;
        for (int i = 0; i < 64; i++)
        begin
            shadow_parent[i] = 0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: small tree under node_count 5
        write_count(5);
        add_req(CMD_WRITE, 0, 0, -1, 0, 0);
        add_req(CMD_WRITE, 1, 0, 0, 0, 0);
        add_req(CMD_WRITE, 2, 0, 0, 0, 0);
        add_req(CMD_WRITE, 3, 0, 1, 0, 0);
        add_req(CMD_WRITE, 4, 0, 1, 0, 0);
        add_req(CMD_WRITE, 63, 63, 63, 127, 0);     // bad index on write
        add_req(CMD_LEVEL, 4, 0, 0, 0, 0);
        add_req(CMD_LCA, 3, 2, 0, 0, 0);
        add_req(CMD_LCA, 4, 3, 0, 0, 0);
        add_req(CMD_CHILDREN, 1, 0, 0, 0, 0);
        add_req(CMD_CHILDREN, 4, 0, 0, 0, 0);       // empty list
        add_req(CMD_SIBLINGS, 0, 0, 0, 0, 0);       // root with no other roots
        add_req(CMD_SIBLINGS, 3, 0, 0, 0, 0);
        add_req(CMD_AT_LEVEL, 0, 0, 0, 3, 0);
        add_req(CMD_AT_LEVEL, 0, 0, 0, 0, 0);       // level zero
        add_req(CMD_AT_LEVEL, 0, 0, 0, 127, 0);     // beyond every level
        add_req(CMD_HEIGHT, 0, 0, 0, 0, 0);
        add_req(CMD_ROOT, 0, 0, 0, 0, 0);
        add_req(CMD_LEVEL, 5, 0, 0, 0, 0);          // bad node
        add_req(CMD_WRITE, 2, 0, -1, 0, 0);         // second root: lca without common root
        add_req(CMD_LCA, 3, 2, 0, 0, 0);
        add_req(CMD_WRITE, 0, 0, 4, 0, 0);          // cycle 0-1-4
        add_req(CMD_HEIGHT, 0, 0, 0, 0, 0);
        add_req(CMD_WRITE, 2, 0, 63, 0, 0);         // parent beyond node count
        add_req(CMD_ROOT, 0, 0, 0, 0, 1);           // pause until drained, then no root left
        wait_drained();

        // random phases over several counts, extremes included
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: phase_n = 1;
                1: phase_n = 64;
                2: phase_n = 2;
                default: phase_n = $urandom_range(3, 16);
            endcase
            write_count(phase_n);
            build_tree(phase_n, $urandom_range(0, 2));
            if (ph == 2)
            begin
                // long receiver hold-off while requests keep coming
                hold_off = 1;
            end
            random_queries(phase_n, (phase_n == 64) ? 12 : 20);
            wait_drained();
        end
        // count field outside 1..64 exercises the clamp on both sides
        write_count(0);
        build_tree(1, 0);
        random_queries(1, 6);
        wait_drained();
        write_count(127);
        build_tree(64, 1);
        add_req(CMD_HEIGHT, 0, 0, 0, 0, 0);
        add_req(CMD_AT_LEVEL, 0, 0, 0, 64, 0);
        add_req(CMD_LCA, 63, 0, 0, 0, 0);
        wait_drained();

        if (error_count == 0)
            $display("parent_array_tree_query_tb: done, clean");
        else
            $display("parent_array_tree_query_tb: done, errors");
        $finish;
    end

endmodule
